FILE: rtl/sha1md_pkg.sv
// sha1md_pkg: shared types, constants and helpers for the SHA-1 digest block.
// Used by sha1md_ctrl, sha1md_dp and sha1_message_digest. No dependencies.
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam int WORD_W  = 32;
    localparam int BLOCK_W = 512;
    localparam int CNT_W   = 3;
    localparam int ROUND_W = 7;
    localparam int OUT_N   = 5;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t H0_INIT = 32'h6745_2301;
    localparam word_t H1_INIT = 32'hEFCD_AB89;
    localparam word_t H2_INIT = 32'h98BA_DCFE;
    localparam word_t H3_INIT = 32'h1032_5476;
    localparam word_t H4_INIT = 32'hC3D2_E1F0;

    localparam word_t K0 = 32'h5A82_7999;
    localparam word_t K1 = 32'h6ED9_EBA1;
    localparam word_t K2 = 32'h8F1B_BCDC;
    localparam word_t K3 = 32'hCA62_C1D6;

    localparam word_t PAD_WORD = 32'h8000_0000;  // 0x80 in the top byte

    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    // byte source for the block buffer
    typedef enum logic [2:0] {
        SRC_IN     = 3'd0,
        SRC_HOLD   = 3'd1,
        SRC_PAD80  = 3'd2,
        SRC_ZERO   = 3'd3,
        SRC_LEN_HI = 3'd4,
        SRC_LEN_LO = 3'd5
    } src_t;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b0_0000_0001,
        ST_ABSORB = 9'b0_0000_0010,
        ST_PAD80  = 9'b0_0000_0100,
        ST_PADZ   = 9'b0_0000_1000,
        ST_LENHI  = 9'b0_0001_0000,
        ST_LENLO  = 9'b0_0010_0000,
        ST_ROUND  = 9'b0_0100_0000,
        ST_FINISH = 9'b0_1000_0000,
        ST_DRAIN  = 9'b1_0000_0000
    } state_t;

    // what follows the current compression
    typedef enum logic [1:0] {
        PH_MSG = 2'd0,
        PH_PAD = 2'd1,
        PH_LEN = 2'd2
    } phase_t;

    typedef struct packed {
        logic absorb;   // append bytes from src to the block buffer
        src_t src;
        logic round;    // run one compression round
        logic finish;   // fold working regs into the chain value
        logic emit;     // move chain value to output words, restart message
    } cmd_t;

    typedef struct packed {
        logic full;          // this absorb completes a 64-byte block
        logic hold_pending;  // leftover bytes of a straddling word
        logic hold_last;     // held word closed the message
        logic fill56;        // buffer holds 56 bytes, room for the length
        logic round_last;
        logic out_busy;
    } status_t;

    function automatic word_t rotl1(input word_t v);
        return {v[WORD_W-2:0], v[WORD_W-1]};
    endfunction

    function automatic word_t rotl5(input word_t v);
        return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
    endfunction

    function automatic word_t rotl30(input word_t v);
        return {v[1:0], v[WORD_W-1:2]};
    endfunction

endpackage

FILE: rtl/sha1md_ctrl.sv
// sha1md_ctrl: sequencer for the SHA-1 digest block.
// Drives absorb, padding, round and output commands. Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  sha1md_pkg::status_t status,
    output sha1md_pkg::cmd_t    cmd
);
    import sha1md_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        cmd.absorb = 1'b0;
        cmd.src    = SRC_HOLD;
        cmd.round  = 1'b0;
        cmd.finish = 1'b0;
        cmd.emit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.src    = SRC_IN;
                cmd.absorb = in_valid;
                if (in_valid)
                begin
                    if (status.full)
                    begin
                        state_next = ST_ROUND;
                        phase_next = PH_MSG;
                    end
                    else if (in_last)
                        state_next = ST_PAD80;
                end
            end
            ST_ABSORB:
            begin
                cmd.absorb = 1'b1;
                cmd.src    = SRC_HOLD;
                if (status.full)
                begin
                    state_next = ST_ROUND;
                    phase_next = PH_MSG;
                end
                else if (status.hold_last)
                    state_next = ST_PAD80;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD80:
            begin
                cmd.absorb = 1'b1;
                cmd.src    = SRC_PAD80;
                if (status.full)
                begin
                    state_next = ST_ROUND;
                    phase_next = PH_PAD;
                end
                else
                    state_next = ST_PADZ;
            end
            ST_PADZ:
            begin
                cmd.src = SRC_ZERO;
                if (status.fill56)
                    state_next = ST_LENHI;
                else
                begin
                    cmd.absorb = 1'b1;
                    if (status.full)
                    begin
                        state_next = ST_ROUND;
                        phase_next = PH_PAD;
                    end
                end
            end
            ST_LENHI:
            begin
                cmd.absorb = 1'b1;
                cmd.src    = SRC_LEN_HI;
                state_next = ST_LENLO;
            end
            ST_LENLO:
            begin
                cmd.absorb = 1'b1;
                cmd.src    = SRC_LEN_LO;
                state_next = ST_ROUND;
                phase_next = PH_LEN;
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                case (phase_reg)
                    PH_MSG:
                    begin
                        if (status.hold_pending)
                            state_next = ST_ABSORB;
                        else if (status.hold_last)
                            state_next = ST_PAD80;
                        else
                            state_next = ST_IDLE;
                    end
                    PH_PAD:  state_next = ST_PADZ;
                    PH_LEN:  state_next = ST_DRAIN;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_DRAIN:
            begin
                // previous digest must be fully taken first
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_MSG;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: rtl/sha1md_dp.sv
// sha1md_dp: datapath of the SHA-1 digest block: byte packer, 512-bit block
// buffer used as rolling schedule, round unit, chain value and output words.
// Depends on sha1md_pkg.
`timescale 1ns / 1ps

module sha1md_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1md_pkg::cmd_t    cmd,
    output sha1md_pkg::status_t status,
    input  logic [31:0]         in_word,
    input  logic [2:0]          in_count,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         out_word,
    output logic                out_last
);
    import sha1md_pkg::*;

    logic [BLOCK_W-1:0] buf_reg;
    logic [5:0]         fill_reg;
    word_t              hold_word_reg;
    logic [CNT_W-1:0]   hold_cnt_reg;
    logic               hold_last_reg;
    logic [63:0]        len_reg;
    word_t              chain_reg [OUT_N];
    word_t              work_reg [OUT_N];
    logic [ROUND_W-1:0] round_reg;
    word_t              out_reg [OUT_N];
    logic [CNT_W-1:0]   out_cnt_reg;

    word_t              src_word;
    logic [CNT_W-1:0]   src_cnt;
    logic [6:0]         room;
    logic [6:0]         zero_rem;
    logic [CNT_W-1:0]   zero_cnt;
    logic [CNT_W-1:0]   take;
    logic [6:0]         fill_sum;
    logic               full;
    logic [BLOCK_W-1:0] buf_absorb;
    word_t              left_word;
    logic               msg_src;

    word_t              w_cur;
    word_t              w_new;
    word_t              f_val;
    word_t              k_val;
    word_t              t_val;

    // zero padding runs up to byte 56, or to the block end when already past it
    always_comb
    begin
        zero_rem = (fill_reg > 6'd56) ? (7'd64 - {1'b0, fill_reg})
                                      : (7'd56 - {1'b0, fill_reg});
        zero_cnt = (zero_rem > 7'd4) ? 3'd4 : zero_rem[CNT_W-1:0];
    end

    always_comb
    begin
        case (cmd.src)
            SRC_IN:
            begin
                src_word = in_word;
                src_cnt  = (in_count > 3'd4) ? 3'd4 : in_count;
            end
            SRC_HOLD:
            begin
                src_word = hold_word_reg;
                src_cnt  = hold_cnt_reg;
            end
            SRC_PAD80:
            begin
                src_word = PAD_WORD;
                src_cnt  = 3'd1;
            end
            SRC_ZERO:
            begin
                src_word = '0;
                src_cnt  = zero_cnt;
            end
            SRC_LEN_HI:
            begin
                src_word = len_reg[63:32];
                src_cnt  = 3'd4;
            end
            SRC_LEN_LO:
            begin
                src_word = len_reg[31:0];
                src_cnt  = 3'd4;
            end
            default:
            begin
                src_word = '0;
                src_cnt  = '0;
            end
        endcase
    end

    assign msg_src  = (cmd.src == SRC_IN) || (cmd.src == SRC_HOLD);
    assign room     = 7'd64 - {1'b0, fill_reg};
    assign take     = ({4'd0, src_cnt} > room) ? room[CNT_W-1:0] : src_cnt;
    assign fill_sum = {1'b0, fill_reg} + {4'd0, take};
    assign full     = cmd.absorb && fill_sum[6];

    // bytes enter at the bottom; the first byte of the block ends on top
    always_comb
    begin
        case (take)
            3'd1:
            begin
                buf_absorb = {buf_reg[BLOCK_W-9:0], src_word[31:24]};
                left_word  = {src_word[23:0], 8'd0};
            end
            3'd2:
            begin
                buf_absorb = {buf_reg[BLOCK_W-17:0], src_word[31:16]};
                left_word  = {src_word[15:0], 16'd0};
            end
            3'd3:
            begin
                buf_absorb = {buf_reg[BLOCK_W-25:0], src_word[31:8]};
                left_word  = {src_word[7:0], 24'd0};
            end
            3'd4:
            begin
                buf_absorb = {buf_reg[BLOCK_W-33:0], src_word};
                left_word  = '0;
            end
            default:
            begin
                buf_absorb = buf_reg;
                left_word  = src_word;
            end
        endcase
    end

    // buffer top word is W[t]; append W[t+16] from W[t], W[t+2], W[t+8], W[t+13]
    assign w_cur = buf_reg[511:480];
    assign w_new = rotl1(buf_reg[511:480] ^ buf_reg[447:416] ^
                         buf_reg[255:224] ^ buf_reg[95:64]);

    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            k_val = K0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3]) |
                    (work_reg[2] & work_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            k_val = K3;
        end
        t_val = rotl5(work_reg[0]) + f_val + work_reg[4] + k_val + w_cur;
    end

    // block buffer and leftover word: payload only
    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
            buf_reg <= buf_absorb;
        else if (cmd.round)
            buf_reg <= {buf_reg[BLOCK_W-33:0], w_new};
        if (cmd.absorb && msg_src)
            hold_word_reg <= left_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            hold_cnt_reg  <= '0;
            hold_last_reg <= 1'b0;
            len_reg       <= '0;
            round_reg     <= '0;
            chain_reg[0]  <= H0_INIT;
            chain_reg[1]  <= H1_INIT;
            chain_reg[2]  <= H2_INIT;
            chain_reg[3]  <= H3_INIT;
            chain_reg[4]  <= H4_INIT;
            for (int i = 0; i < OUT_N; i++)
                work_reg[i] <= '0;
        end
        else
        begin
            if (cmd.absorb)
                fill_reg <= fill_sum[5:0];
            if (cmd.absorb && msg_src)
            begin
                hold_cnt_reg <= src_cnt - take;
                len_reg      <= len_reg + {58'd0, take, 3'd0};
            end
            if (cmd.absorb && (cmd.src == SRC_IN))
                hold_last_reg <= in_last;

            if (full)
            begin
                round_reg <= '0;
                for (int i = 0; i < OUT_N; i++)
                    work_reg[i] <= chain_reg[i];
            end
            else if (cmd.round)
            begin
                round_reg   <= round_reg + 7'd1;
                work_reg[0] <= t_val;
                work_reg[1] <= work_reg[0];
                work_reg[2] <= rotl30(work_reg[1]);
                work_reg[3] <= work_reg[2];
                work_reg[4] <= work_reg[3];
            end

            if (cmd.finish)
            begin
                for (int i = 0; i < OUT_N; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
            else if (cmd.emit)
            begin
                chain_reg[0] <= H0_INIT;
                chain_reg[1] <= H1_INIT;
                chain_reg[2] <= H2_INIT;
                chain_reg[3] <= H3_INIT;
                chain_reg[4] <= H4_INIT;
                len_reg      <= '0;
                fill_reg     <= '0;
            end
        end
    end

    // output words: H0 on top, shifted out one word per handshake
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            for (int i = 0; i < OUT_N; i++)
                out_reg[i] <= chain_reg[i];
        end
        else if (out_valid && out_ready)
        begin
            for (int i = 0; i < OUT_N - 1; i++)
                out_reg[i] <= out_reg[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_cnt_reg <= '0;
        else if (cmd.emit)
            out_cnt_reg <= CNT_W'(OUT_N);
        else if (out_valid && out_ready)
            out_cnt_reg <= out_cnt_reg - 3'd1;
    end

    assign out_valid = (out_cnt_reg != '0);
    assign out_word  = out_reg[0];
    assign out_last  = (out_cnt_reg == 3'd1);

    assign status.full         = full;
    assign status.hold_pending = (hold_cnt_reg != '0);
    assign status.hold_last    = hold_last_reg;
    assign status.fill56       = (fill_reg == 6'd56);
    assign status.round_last   = (round_reg == ROUND_LAST);
    assign status.out_busy     = out_valid;

endmodule

FILE: rtl/sha1_message_digest.sv
// sha1_message_digest: streaming SHA-1 engine, top level.
// Instantiates sha1md_ctrl and sha1md_dp; types from sha1md_pkg.
//
//   channel  dir  handshake                   tdata / tlast
//   s_axis   in   s_axis_tvalid/tready        [31:0] message_word, [34:32] valid_bytes;
//                                             tlast = final_word
//   m_axis   out  m_axis_tvalid/tready        [31:0] digest_word; tlast = digest_last
//
// A full message word is taken while the sequencer is idle. Every completed 64-byte
// block is followed by 80 rounds of the single round unit plus the chain update,
// during which input is stalled. After the final word, padding adds one or two block
// compressions. Reset is asynchronous, active low; the chain value returns to the
// initial constants. The five digest words sit in an output buffer, so the next message
// can start while they drain; a second digest waits until the buffer is empty.
`timescale 1ns / 1ps

module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [31:0] message_word, [34:32] valid_bytes
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast
);
    import sha1md_pkg::*;

    cmd_t    cmd;
    status_t status;

    sha1md_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sha1md_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_word   (s_axis_tdata[31:0]),
        .in_count  (s_axis_tdata[34:32]),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for sha1_message_digest (streaming SHA-1).
// Holds its own SHA-1 predictor in a scoreboard class; needs sha1md_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    import sha1md_pkg::*;

    localparam int RAND_WORDS = 360;
    localparam int MAX_STALL  = 19;
    localparam int DRAIN_WAIT = 300;
    localparam int MAX_BYTES  = 4;

    // Running SHA-1 state plus the queue of digest words still owed by the block.
    class digest_scoreboard;
        word_t       chain[OUT_N];
        word_t       blk[16];
        int unsigned fill;
        logic [63:0] bit_len;
        word_t       digest_q[$];
        logic        last_q[$];
        int unsigned errors;

        function new();
            errors = 0;
            restart_message();
        endfunction

        function void restart_message();
            chain[0] = H0_INIT;
            chain[1] = H1_INIT;
            chain[2] = H2_INIT;
            chain[3] = H3_INIT;
            chain[4] = H4_INIT;
            bit_len  = '0;
            fill     = 0;
        endfunction

        function void compress_block();
            word_t sched[16];
            word_t a, b, c, d, e, f, k, t, x;
            int    r;
            sched = blk;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (r = 0; r < 80; r++)
            begin
                if (r >= 16)
                begin
                    x = sched[4'((r + 13) & 15)] ^ sched[4'((r + 8) & 15)] ^
                        sched[4'((r + 2) & 15)] ^ sched[4'(r & 15)];
                    sched[4'(r & 15)] = {x[30:0], x[31]};
                end
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K0;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = K1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K3;
                end
                t = {a[26:0], a[31:27]} + f + e + k + sched[4'(r & 15)];
                e = d;
                d = c;
                c = {b[1:0], b[31:2]};
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void put_byte(logic [7:0] value);
            int unsigned sh;
            sh = 24 - 8 * (fill % 4);
            blk[4'(fill / 4)][sh +: 8] = value;
            fill = (fill + 1) % 64;
            if (fill == 0)
                compress_block();
        endfunction

        // one accepted input word
        function void note_word(word_t w, logic [2:0] cnt, logic fin);
            int unsigned n;
            int          i;
            logic [63:0] len;
            n = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
            for (i = 0; i < n; i++)
            begin
                put_byte(w[31 - 8 * i -: 8]);
                bit_len += 8;
            end
            if (!fin)
                return;
            len = bit_len;
            put_byte(PAD_WORD[31:24]);
            while (fill != 56)
                put_byte(8'h00);
            blk[14] = len[63:32];
            blk[15] = len[31:0];
            fill = 0;
            compress_block();
            for (i = 0; i < OUT_N; i++)
            begin
                digest_q.push_back(chain[i]);
                last_q.push_back(i == OUT_N - 1);
            end
            restart_message();
        endfunction

        function void check_word(word_t data, logic last);
            word_t exp_word;
            logic  exp_last;
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest word: expected none, actual %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            exp_word = digest_q.pop_front();
            exp_last = last_q.pop_front();
            if (data !== exp_word)
            begin
                $display("%0t: digest word mismatch: expected %h, actual %h",
                         $time, exp_word, data);
                errors++;
            end
            if (last !== exp_last)
            begin
                $display("%0t: tlast mismatch: expected %b, actual %b", $time, exp_last, last);
                errors++;
            end
        endfunction

        function int pending();
            return digest_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // [31:0] message_word, [34:32] valid_bytes
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [31:0] digest_word
    logic        m_axis_tlast;

    digest_scoreboard sb = new();
    bit               src_quiet = 1'b0;

    sha1_message_digest dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // pre-edge values are sampled here; DUT updates land in the NBA region
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    task automatic send_word(input word_t w, input logic [2:0] cnt, input logic fin);
        int unsigned gap;
        gap = src_quiet ? 0 : $urandom_range(0, MAX_STALL);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, cnt, w};
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // sink side: random stalls, with occasional stretches of steady tready
    initial
    begin
        int unsigned stall;
        int unsigned quiet_left;
        quiet_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet_left > 0)
            begin
                stall = 0;
                quiet_left--;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                stall = 0;
                quiet_left = $urandom_range(10, 40);
            end
            else
                stall = $urandom_range(0, MAX_STALL);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin
        int          i;
        int          sent;
        int          nwords;
        logic [2:0]  cnt;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then "abc"
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        // short words mid-message, counts above four, empty non-final word
        send_word(32'hFFFF_FFFF, 3'd1, 1'b0);
        send_word(32'h1234_5678, 3'd0, 1'b0);
        send_word(32'h0000_0000, 3'd7, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
        // 56 bytes: the length no longer fits, padding spills into a second block
        for (i = 0; i < 14; i++)
        begin
            cnt = (i == 3) ? 3'd5 : (i == 7) ? 3'd6 : (i == 11) ? 3'd7 : 3'd4;
            send_word((i % 2) ? 32'hFFFF_FFFF : 32'h0000_0000, cnt, i == 13);
        end

        sent = 0;
        while (sent < RAND_WORDS)
        begin
            src_quiet = ($urandom_range(0, 3) == 0);
            nwords = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(0, 16);
            for (i = 0; i < nwords; i++)
            begin
                cnt = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                send_word($urandom(), cnt, 1'b0);
            end
            send_word($urandom(), 3'($urandom_range(0, 7)), 1'b1);
            sent += nwords + 1;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("%0t: timeout with %0d digest words outstanding", $time, sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: files.f
rtl/sha1md_pkg.sv
rtl/sha1md_ctrl.sv
rtl/sha1md_dp.sv
rtl/sha1_message_digest.sv
dv/testbench.sv
